// ===== rtl/core/dss_pkg.sv =====
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants of the delimiter string splitter.
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int MaxPatternDef = 8;
  localparam int CharBitsDef   = 8;
  localparam int CfgDataW      = 64;
  localparam int CfgIdxW       = 1;
  localparam int LenRegW       = 4;

  localparam logic [CfgIdxW-1:0] CfgDelimBytes = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgDelimLen   = 1'b1;

  localparam logic [CfgDataW-1:0] DelimBytesRst = 64'd44;
  localparam logic [LenRegW-1:0]  DelimLenRst   = 4'd1;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FLUSH,
    ST_CLOSE
  } state_e;

  typedef struct packed {
    logic char_valid;
    logic field_end;
    logic stream_end;
  } res_flags_t;

endpackage

// ===== rtl/core/dss_if.sv =====
// ----------------------------------------------------------------------------
// dss_if
// Valid/ready channels of the splitter: character input and result output.
// ----------------------------------------------------------------------------
interface dss_in_if #(
  parameter int CHAR_BITS = dss_pkg::CharBitsDef
);
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] in_char;
  logic                 in_last;

  modport source (output valid, in_char, in_last, input ready);
  modport sink   (input valid, in_char, in_last, output ready);
endinterface

interface dss_out_if #(
  parameter int CHAR_BITS = dss_pkg::CharBitsDef
);
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] out_char;
  logic                 char_valid;
  logic                 field_end;
  logic                 stream_end;

  modport source (output valid, out_char, char_valid, field_end, stream_end, input ready);
  modport sink   (input valid, out_char, char_valid, field_end, stream_end, output ready);
endinterface

// ===== rtl/core/dss_cell.sv =====
// ----------------------------------------------------------------------------
// dss_cell
// One window cell: compares the character passing through with its aligned
// pattern character and holds it for the next cell.
// ----------------------------------------------------------------------------
module dss_cell #(
  parameter int CHAR_BITS = dss_pkg::CharBitsDef
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [CHAR_BITS-1:0] d_i,
  input  logic [CHAR_BITS-1:0] pat_i,
  output logic [CHAR_BITS-1:0] q_o,
  output logic                 eq_o
);

  logic [CHAR_BITS-1:0] chr_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      chr_q <= d_i;
    end
  end

  assign q_o  = chr_q;
  assign eq_o = (d_i == pat_i);

endmodule

// ===== rtl/core/dss_outq.sv =====
// ----------------------------------------------------------------------------
// dss_outq
// Two-entry result queue; the head drives the output channel from registers.
// ----------------------------------------------------------------------------
module dss_outq #(
  parameter int CHAR_BITS = dss_pkg::CharBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [CHAR_BITS-1:0] push_char_i,
  input  dss_pkg::res_flags_t  push_flags_i,
  output logic                 full_o,
  dss_out_if.source            out_o
);
  import dss_pkg::*;

  logic [1:0]           cnt_q, cnt_d;
  logic [CHAR_BITS-1:0] ch0_q, ch0_d, ch1_q, ch1_d;
  res_flags_t           fl0_q, fl0_d, fl1_q, fl1_d;
  logic                 pop;

  assign pop    = out_o.valid && out_o.ready;
  assign full_o = (cnt_q == 2'd2);

  always_comb begin
    cnt_d = cnt_q;
    ch0_d = ch0_q;
    fl0_d = fl0_q;
    ch1_d = ch1_q;
    fl1_d = fl1_q;
    if (pop && push_i) begin
      if (cnt_q == 2'd1) begin
        ch0_d = push_char_i;
        fl0_d = push_flags_i;
      end else begin
        ch0_d = ch1_q;
        fl0_d = fl1_q;
        ch1_d = push_char_i;
        fl1_d = push_flags_i;
      end
    end else if (pop) begin
      ch0_d = ch1_q;
      fl0_d = fl1_q;
      cnt_d = cnt_q - 2'd1;
    end else if (push_i) begin
      if (cnt_q == 2'd0) begin
        ch0_d = push_char_i;
        fl0_d = push_flags_i;
      end else begin
        ch1_d = push_char_i;
        fl1_d = push_flags_i;
      end
      cnt_d = cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch0_q <= ch0_d;
    fl0_q <= fl0_d;
    ch1_q <= ch1_d;
    fl1_q <= fl1_d;
  end

  assign out_o.valid      = (cnt_q != 2'd0);
  assign out_o.out_char   = ch0_q;
  assign out_o.char_valid = fl0_q.char_valid;
  assign out_o.field_end  = fl0_q.field_end;
  assign out_o.stream_end = fl0_q.stream_end;

endmodule

// ===== rtl/core/dss_ctrl.sv =====
// ----------------------------------------------------------------------------
// dss_ctrl
// Configuration registers, window fill count, flush sequencer and the
// pending result that carries the end-of-stream mark.
// ----------------------------------------------------------------------------
module dss_ctrl #(
  parameter int MAX_PATTERN = dss_pkg::MaxPatternDef,
  parameter int CHAR_BITS   = dss_pkg::CharBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [dss_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  logic [dss_pkg::CfgDataW-1:0]          cfg_data_i,
  dss_in_if.sink                                in_i,
  input  logic                                  q_full_i,
  input  logic [MAX_PATTERN-1:0][CHAR_BITS-1:0] link_i,
  input  logic [MAX_PATTERN-1:0]                eq_i,
  output logic                                  feed_en_o,
  output logic [CHAR_BITS-1:0]                  feed_char_o,
  output logic [MAX_PATTERN-1:0][CHAR_BITS-1:0] pat_al_o,
  output logic                                  push_o,
  output logic [CHAR_BITS-1:0]                  push_char_o,
  output dss_pkg::res_flags_t                   push_flags_o
);
  import dss_pkg::*;

  localparam int FillW = $clog2(MAX_PATTERN + 1);
  localparam int IdxW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int ExtW  = CfgDataW + MAX_PATTERN * CHAR_BITS;

  state_e               state_q, state_d;
  logic [CfgDataW-1:0]  bytes_q, bytes_d;
  logic [LenRegW-1:0]   len_q, len_d;
  logic [FillW-1:0]     fill_q, fill_d;
  logic [IdxW-1:0]      k_q, k_d;
  logic                 pend_vld_q, pend_vld_d;
  logic [CHAR_BITS-1:0] pend_chr_q, pend_chr_d;
  res_flags_t           pend_fl_q, pend_fl_d;

  logic [FillW-1:0]     len_eff, len_m1, fill_cur, fill_inc;
  logic [ExtW-1:0]      pat_ext;
  logic [MAX_PATTERN-1:0][CHAR_BITS-1:0] pat_chr;
  logic [MAX_PATTERN-1:0][FillW-1:0]     al_idx;
  logic [MAX_PATTERN-1:0] active;
  logic                 space, full, match, pend_mode, close;
  logic                 res_vld;
  logic [CHAR_BITS-1:0] res_chr;
  res_flags_t           res_fl;

  // effective pattern length and aligned pattern characters
  always_comb begin
    if (len_q == '0) begin
      len_eff = FillW'(1);
    end else if (len_q > LenRegW'(MAX_PATTERN)) begin
      len_eff = FillW'(MAX_PATTERN);
    end else begin
      len_eff = len_q[FillW-1:0];
    end
  end

  assign len_m1  = len_eff - FillW'(1);
  assign pat_ext = {{(MAX_PATTERN * CHAR_BITS){1'b0}}, bytes_q};

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pat
    assign pat_chr[k] = pat_ext[k * CHAR_BITS +: CHAR_BITS];
    assign al_idx[k]  = len_eff - FillW'(k + 1);
    assign pat_al_o[k] = pat_chr[al_idx[k][IdxW-1:0]];
    assign active[k]  = (FillW'(k) < len_eff);
  end

  assign space = !q_full_i;

  // sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN: begin
        if (in_i.valid && space && in_i.in_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (space && (k_q == len_m1[IdxW-1:0])) begin
          state_d = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        if (space) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_i.ready  = 1'b0;
    feed_en_o   = 1'b0;
    feed_char_o = in_i.in_char;
    pend_mode   = 1'b0;
    close       = 1'b0;
    unique case (state_q)
      ST_RUN: begin
        in_i.ready = space;
        feed_en_o  = in_i.valid && space;
        pend_mode  = in_i.in_last;
      end
      ST_FLUSH: begin
        feed_en_o   = space;
        feed_char_o = pat_chr[k_q];
        pend_mode   = 1'b1;
      end
      ST_CLOSE: begin
        close = space;
      end
      default: begin
        close = 1'b0;
      end
    endcase
  end

  // window decision
  assign fill_cur = (fill_q >= len_eff) ? '0 : fill_q;
  assign fill_inc = fill_cur + FillW'(1);
  assign full     = (fill_inc == len_eff);
  assign match    = &(eq_i | ~active);
  assign res_vld  = feed_en_o && full;
  assign res_chr  = match ? '0 : link_i[len_m1[IdxW-1:0]];

  always_comb begin
    res_fl            = '0;
    res_fl.char_valid = !match;
    res_fl.field_end  = match;
  end

  always_comb begin
    bytes_d = bytes_q;
    len_d   = len_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDelimBytes: bytes_d = cfg_data_i;
        CfgDelimLen:   len_d   = cfg_data_i[LenRegW-1:0];
      endcase
    end
  end

  always_comb begin
    fill_d       = fill_q;
    k_d          = k_q;
    pend_vld_d   = pend_vld_q;
    pend_chr_d   = pend_chr_q;
    pend_fl_d    = pend_fl_q;
    push_o       = 1'b0;
    push_char_o  = res_chr;
    push_flags_o = res_fl;

    if (state_q == ST_RUN) begin
      k_d = '0;
    end else if (state_q == ST_FLUSH && space) begin
      k_d = k_q + IdxW'(1);
    end

    if (feed_en_o) begin
      if (!full) begin
        fill_d = fill_inc;
      end else if (match) begin
        fill_d = '0;
      end else begin
        fill_d = len_m1;
      end
    end

    // hold results of a closing step so the final one can carry stream end
    if (res_vld) begin
      if (pend_mode) begin
        push_o       = pend_vld_q;
        push_char_o  = pend_chr_q;
        push_flags_o = pend_fl_q;
        pend_vld_d   = 1'b1;
        pend_chr_d   = res_chr;
        pend_fl_d    = res_fl;
      end else begin
        push_o = 1'b1;
      end
    end

    if (close) begin
      push_o                  = pend_vld_q;
      push_char_o             = pend_chr_q;
      push_flags_o            = pend_fl_q;
      push_flags_o.stream_end = 1'b1;
      pend_vld_d              = 1'b0;
      fill_d                  = '0;
    end

    if (cfg_we_i) begin
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_RUN;
      bytes_q    <= DelimBytesRst;
      len_q      <= DelimLenRst;
      fill_q     <= '0;
      k_q        <= '0;
      pend_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      bytes_q    <= bytes_d;
      len_q      <= len_d;
      fill_q     <= fill_d;
      k_q        <= k_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_chr_q <= pend_chr_d;
    pend_fl_q  <= pend_fl_d;
  end

endmodule

// ===== rtl/core/delimiter_string_splitter.sv =====
// ----------------------------------------------------------------------------
// delimiter_string_splitter
// Splits a character stream into fields at each leftmost, non-overlapping
// occurrence of a programmable delimiter pattern.
// ----------------------------------------------------------------------------
// One character enters per cycle while the result queue has room. A row of
// MAX_PATTERN cells holds the most recent characters and compares them with
// the pattern in parallel; each character that completes the window yields
// either a field end or its oldest character. The character that closes a
// string starts a flush: the pattern is fed through the row one character
// per cycle while the queue has room; then the final result leaves with
// stream_end. Input is held off meanwhile. Results leave through a two-entry
// queue, so one character is still taken while a result waits on the output.
// Writing either register restarts the window; write only while idle.
module delimiter_string_splitter #(
  parameter int MAX_PATTERN = dss_pkg::MaxPatternDef,
  parameter int CHAR_BITS   = dss_pkg::CharBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dss_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dss_pkg::CfgDataW-1:0] cfg_data_i,
  dss_in_if.sink                       in_i,
  dss_out_if.source                    out_o
);
  import dss_pkg::*;

  logic                                  feed_en;
  logic [CHAR_BITS-1:0]                  feed_char;
  logic [MAX_PATTERN-1:0][CHAR_BITS-1:0] link;
  logic [MAX_PATTERN-1:0][CHAR_BITS-1:0] pat_al;
  logic [MAX_PATTERN-1:0]                eq;
  logic                                  q_full;
  logic                                  push;
  logic [CHAR_BITS-1:0]                  push_char;
  res_flags_t                            push_flags;

  assign link[0] = feed_char;

  dss_ctrl #(
    .MAX_PATTERN (MAX_PATTERN),
    .CHAR_BITS   (CHAR_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_i         (in_i),
    .q_full_i     (q_full),
    .link_i       (link),
    .eq_i         (eq),
    .feed_en_o    (feed_en),
    .feed_char_o  (feed_char),
    .pat_al_o     (pat_al),
    .push_o       (push),
    .push_char_o  (push_char),
    .push_flags_o (push_flags)
  );

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    if (j < MAX_PATTERN - 1) begin : g_mid
      dss_cell #(
        .CHAR_BITS (CHAR_BITS)
      ) u_cell (
        .clk_i (clk_i),
        .en_i  (feed_en),
        .d_i   (link[j]),
        .pat_i (pat_al[j]),
        .q_o   (link[j+1]),
        .eq_o  (eq[j])
      );
    end else begin : g_end
      dss_cell #(
        .CHAR_BITS (CHAR_BITS)
      ) u_cell (
        .clk_i (clk_i),
        .en_i  (feed_en),
        .d_i   (link[j]),
        .pat_i (pat_al[j]),
        .q_o   (),
        .eq_o  (eq[j])
      );
    end
  end

  dss_outq #(
    .CHAR_BITS (CHAR_BITS)
  ) u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_char_i  (push_char),
    .push_flags_i (push_flags),
    .full_o       (q_full),
    .out_o        (out_o)
  );

endmodule
